FILE: src/rcd_pkg.sv
// Shared constants and types for the grid ray caster.
// No dependencies; used by rcd_div, the top level and the testbench.
package rcd_pkg;

  localparam int MAP_SIZE  = 32;
  localparam int CELL_BITS = 4;
  localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int CRD_W     = 8;
  localparam int STEP_MAX  = 2 * MAP_SIZE + 2;
  localparam int STEP_W    = $clog2(STEP_MAX + 1);
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [25:0] DIST_MAX = 26'h3FF_FFFF;
  localparam logic [15:0] LH_MAX   = 16'hFFFF;
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;

  typedef enum logic [1:0] {
    ST_WRITE = 2'd0,
    ST_HIT   = 2'd1,
    ST_LEFT  = 2'd2
  } status_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

endpackage

FILE: src/rcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/rcd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on rcd_pkg for the operand width.
module rcd_div
  import rcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [DIV_W-1:0]     den_r, den_nxt;
  logic [DIV_W:0]       sh;

  assign sh = {rem_r, q_r[DIV_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    if (go && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = DIV_W'(sh - {1'b0, den_r});
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DIV_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

FILE: src/grid_ray_caster_dda_top.sv
// Grid ray caster top level: sequencer, shared multiplier and map store.
// Depends on rcd_pkg, rcd_ram and rcd_div.
//
// Usage: a word is taken at a rising edge with start high and busy low.
// req_type 0 writes one map cell; the result (status 0) appears the next
// cycle and busy stays low. req_type 1 casts one ray. One division on the
// shared divider forms camera x, two shared multiplies form the ray, two
// more divisions give the step distances, the side distances are set up
// (S_SX, S_SY, S_SI), then the walk steps, checks and reads the map for
// each cell visited (S_STEP, S_CHK, S_RD; the map read is registered), and
// a last division gives the line height. The walk visits at most 66 cells;
// a ray that leaves the grid ends without the last division.
// busy stays high for the whole cast, so one word is in flight at a time.
// Each result is shown for one cycle with out_valid high; the receiver
// cannot stall. After reset the map is cleared one cell a cycle with busy
// high; configuration writes are taken at any time and reset to a 640 x
// 480 screen.
module grid_ray_caster_dda_top
  import rcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [4:0]  in_cell_x,
  input  logic [4:0]  in_cell_y,
  input  logic [3:0]  in_cell_value,
  input  logic [10:0] in_column,
  input  logic [14:0] in_pos_x,
  input  logic [14:0] in_pos_y,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_plane_x,
  input  logic signed [15:0] in_plane_y,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [25:0] out_perp_dist,
  output logic        out_hit_side,
  output logic [4:0]  out_hit_x,
  output logic [4:0]  out_hit_y,
  output logic [3:0]  out_wall_value,
  output logic [15:0] out_slice_len,
  output logic [10:0] out_span_top,
  output logic [10:0] out_span_bot,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [11:0] cfg_wdata
);

  typedef enum logic [14:0] {
    S_CLR  = 15'h0001,
    S_IDLE = 15'h0002,
    S_WCAM = 15'h0004,
    S_MX   = 15'h0008,
    S_MY   = 15'h0010,
    S_RY   = 15'h0020,
    S_WDX  = 15'h0040,
    S_WDY  = 15'h0080,
    S_SX   = 15'h0100,
    S_SY   = 15'h0200,
    S_SI   = 15'h0400,
    S_STEP = 15'h0800,
    S_CHK  = 15'h1000,
    S_RD   = 15'h2000,
    S_WLH  = 15'h4000
  } state_t;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [11:0] width_r, height_r;

  logic signed [15:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [15:0] plx_r, plx_nxt, ply_r, ply_nxt;
  logic [9:0]  fx_r, fx_nxt, fy_r, fy_nxt;
  logic signed [27:0] cam_r, cam_nxt;
  logic signed [45:0] prod_r, prod_nxt;
  logic signed [32:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [25:0] ddx_r, ddx_nxt, ddy_r, ddy_nxt;
  logic [33:0] sdx_r, sdx_nxt, sdy_r, sdy_nxt;
  logic signed [CRD_W-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic        side_r, side_nxt;
  logic [STEP_W-1:0] n_r, n_nxt;
  logic [3:0]  val_r, val_nxt;
  logic [25:0] perp_r, perp_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     status_r, status_nxt;
  logic [25:0] perp_o_r, perp_o_nxt;
  logic        side_o_r, side_o_nxt;
  logic [4:0]  hx_r, hx_nxt, hy_r, hy_nxt;
  logic [3:0]  wv_r, wv_nxt;
  logic [15:0] lh_r, lh_nxt;
  logic [10:0] ds_r, ds_nxt, de_r, de_nxt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [CELL_BITS-1:0] ram_wdata, ram_rdata;

  logic             div_go, div_done;
  logic [DIV_W-1:0] div_num, div_den, div_quo;

  logic signed [16:0] mul_a;
  logic signed [28:0] mul_b;
  logic [31:0] abs_rx, abs_ry;
  logic [10:0] fsel_x, fsel_y;
  logic [25:0] dd_sat;
  logic [33:0] perp_raw;
  logic [25:0] perp_c;
  logic        in_grid;
  logic        start_out;
  logic [15:0] lhq;
  logic [10:0] h2;
  logic [14:0] lh2;
  logic [16:0] de_sum;
  logic [16:0] de_w;

  assign abs_rx = rx_r[32] ? 32'(-rx_r) : rx_r[31:0];
  assign abs_ry = ry_r[32] ? 32'(-ry_r) : ry_r[31:0];
  assign fsel_x = rx_r[32] ? {1'b0, fx_r} : 11'd1024 - {1'b0, fx_r};
  assign fsel_y = ry_r[32] ? {1'b0, fy_r} : 11'd1024 - {1'b0, fy_r};
  assign dd_sat = (div_quo > DIV_W'(DIST_MAX)) ? DIST_MAX : div_quo[25:0];
  assign perp_raw = side_r ? (sdy_r - 34'(ddy_r)) : (sdx_r - 34'(ddx_r));
  assign perp_c = (perp_raw > 34'(DIST_MAX)) ? DIST_MAX : perp_raw[25:0];
  assign in_grid = !mx_r[CRD_W-1] && !my_r[CRD_W-1]
                   && (mx_r < CRD_W'(MAP_SIZE)) && (my_r < CRD_W'(MAP_SIZE));
  assign start_out = (mx_r >= CRD_W'(MAP_SIZE)) || (my_r >= CRD_W'(MAP_SIZE));
  assign lhq = (div_quo[31:16] != 16'd0) ? LH_MAX : div_quo[15:0];
  assign h2 = height_r[11:1];
  assign lh2 = lhq[15:1];
  assign de_sum = 17'(lh2) + 17'(h2);
  assign ram_raddr = ADDR_W'(my_r[CRD_W-2:0]) * ADDR_W'(MAP_SIZE)
                     + ADDR_W'(mx_r[CRD_W-2:0]);

  always_comb begin
    case (state_r)
      S_MY: begin
        mul_a = 17'(ply_r);
        mul_b = 29'(cam_r);
      end
      S_SX: begin
        mul_a = {6'd0, fsel_x};
        mul_b = {3'd0, ddx_r};
      end
      S_SY: begin
        mul_a = {6'd0, fsel_y};
        mul_b = {3'd0, ddy_r};
      end
      default: begin
        mul_a = 17'(plx_r);
        mul_b = 29'(cam_r);
      end
    endcase
  end

  always_comb begin
    if (de_sum >= 17'(height_r)) begin
      de_w = (height_r == 12'd0) ? 17'd0 : 17'(height_r - 12'd1);
    end else begin
      de_w = de_sum;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    dx_nxt = dx_r;  dy_nxt = dy_r;
    plx_nxt = plx_r; ply_nxt = ply_r;
    fx_nxt = fx_r;  fy_nxt = fy_r;
    cam_nxt = cam_r;
    prod_nxt = prod_r;
    rx_nxt = rx_r;  ry_nxt = ry_r;
    ddx_nxt = ddx_r; ddy_nxt = ddy_r;
    sdx_nxt = sdx_r; sdy_nxt = sdy_r;
    mx_nxt = mx_r;  my_nxt = my_r;
    side_nxt = side_r;
    n_nxt = n_r;
    val_nxt = val_r;
    perp_nxt = perp_r;
    out_valid_nxt = 1'b0;
    status_nxt = status_r;
    perp_o_nxt = perp_o_r;
    side_o_nxt = side_o_r;
    hx_nxt = hx_r; hy_nxt = hy_r;
    wv_nxt = wv_r;
    lh_nxt = lh_r;
    ds_nxt = ds_r; de_nxt = de_r;
    ram_we = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    div_go = 1'b0;
    div_num = '0;
    div_den = '0;

    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(MAP_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (!in_req_type) begin
            ram_we = (CRD_W'(in_cell_x) < CRD_W'(MAP_SIZE))
                     && (CRD_W'(in_cell_y) < CRD_W'(MAP_SIZE));
            ram_waddr = ADDR_W'(in_cell_y) * ADDR_W'(MAP_SIZE) + ADDR_W'(in_cell_x);
            ram_wdata = CELL_BITS'(in_cell_value);
            out_valid_nxt = 1'b1;
            status_nxt = ST_WRITE;
            perp_o_nxt = '0; side_o_nxt = 1'b0; hx_nxt = '0; hy_nxt = '0;
            wv_nxt = '0; lh_nxt = '0; ds_nxt = '0; de_nxt = '0;
          end else begin
            dx_nxt = in_dir_x;  dy_nxt = in_dir_y;
            plx_nxt = in_plane_x; ply_nxt = in_plane_y;
            fx_nxt = in_pos_x[9:0]; fy_nxt = in_pos_y[9:0];
            mx_nxt = CRD_W'(in_pos_x[14:10]);
            my_nxt = CRD_W'(in_pos_y[14:10]);
            div_go = 1'b1;
            div_num = DIV_W'({in_column, 15'd0});
            div_den = (width_r == 12'd0) ? DIV_W'(1) : DIV_W'(width_r);
            state_nxt = S_WCAM;
          end
        end
      end
      S_WCAM: begin
        if (div_done) begin
          cam_nxt = 28'(div_quo) - 28'sd16384;
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        prod_nxt = mul_a * mul_b;
        state_nxt = S_MY;
      end
      S_MY: begin
        rx_nxt = 33'(dx_r) + 33'(prod_r >>> 14);
        prod_nxt = mul_a * mul_b;
        state_nxt = S_RY;
      end
      S_RY: begin
        ry_nxt = 33'(dy_r) + 33'(prod_r >>> 14);
        div_go = 1'b1;
        div_num = DIV_W'(1) << 30;
        div_den = abs_rx;
        state_nxt = S_WDX;
      end
      S_WDX: begin
        if (div_done) begin
          ddx_nxt = dd_sat;
          div_go = 1'b1;
          div_num = DIV_W'(1) << 30;
          div_den = abs_ry;
          state_nxt = S_WDY;
        end
      end
      S_WDY: begin
        if (div_done) begin
          ddy_nxt = dd_sat;
          state_nxt = S_SX;
        end
      end
      S_SX: begin
        prod_nxt = mul_a * mul_b;
        state_nxt = S_SY;
      end
      S_SY: begin
        sdx_nxt = 34'(prod_r[45:10]);
        prod_nxt = mul_a * mul_b;
        state_nxt = S_SI;
      end
      S_SI: begin
        sdy_nxt = 34'(prod_r[45:10]);
        n_nxt = '0;
        side_nxt = 1'b0;
        if (start_out) begin
          out_valid_nxt = 1'b1;
          status_nxt = ST_LEFT;
          perp_o_nxt = '0; side_o_nxt = 1'b0; hx_nxt = '0; hy_nxt = '0;
          wv_nxt = '0; lh_nxt = '0; ds_nxt = '0; de_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (sdx_r < sdy_r) begin
          sdx_nxt = sdx_r + 34'(ddx_r);
          mx_nxt = rx_r[32] ? mx_r - 1'b1 : mx_r + 1'b1;
          side_nxt = 1'b0;
        end else begin
          sdy_nxt = sdy_r + 34'(ddy_r);
          my_nxt = ry_r[32] ? my_r - 1'b1 : my_r + 1'b1;
          side_nxt = 1'b1;
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (in_grid) begin
          state_nxt = S_RD;
        end else begin
          out_valid_nxt = 1'b1;
          status_nxt = ST_LEFT;
          perp_o_nxt = '0; side_o_nxt = 1'b0; hx_nxt = '0; hy_nxt = '0;
          wv_nxt = '0; lh_nxt = '0; ds_nxt = '0; de_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        if (ram_rdata != '0) begin
          val_nxt = 4'(ram_rdata);
          perp_nxt = perp_c;
          div_go = 1'b1;
          div_num = DIV_W'({height_r, 16'd0});
          div_den = DIV_W'(perp_c);
          state_nxt = S_WLH;
        end else if (n_r == STEP_W'(STEP_MAX - 1)) begin
          out_valid_nxt = 1'b1;
          status_nxt = ST_LEFT;
          perp_o_nxt = '0; side_o_nxt = 1'b0; hx_nxt = '0; hy_nxt = '0;
          wv_nxt = '0; lh_nxt = '0; ds_nxt = '0; de_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          n_nxt = n_r + 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_WLH: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          status_nxt = ST_HIT;
          perp_o_nxt = perp_r;
          side_o_nxt = side_r;
          hx_nxt = mx_r[4:0];
          hy_nxt = my_r[4:0];
          wv_nxt = val_r;
          lh_nxt = lhq;
          ds_nxt = (15'(h2) > lh2) ? 11'(15'(h2) - lh2) : 11'd0;
          de_nxt = (de_w > 17'd2047) ? 11'd2047 : de_w[10:0];
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_addr == CFG_WIDTH) begin
          width_r <= cfg_wdata;
        end else begin
          height_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;  dy_r <= dy_nxt;
    plx_r <= plx_nxt; ply_r <= ply_nxt;
    fx_r <= fx_nxt;  fy_r <= fy_nxt;
    cam_r <= cam_nxt;
    prod_r <= prod_nxt;
    rx_r <= rx_nxt;  ry_r <= ry_nxt;
    ddx_r <= ddx_nxt; ddy_r <= ddy_nxt;
    sdx_r <= sdx_nxt; sdy_r <= sdy_nxt;
    mx_r <= mx_nxt;  my_r <= my_nxt;
    side_r <= side_nxt;
    n_r <= n_nxt;
    val_r <= val_nxt;
    perp_r <= perp_nxt;
    status_r <= status_nxt;
    perp_o_r <= perp_o_nxt;
    side_o_r <= side_o_nxt;
    hx_r <= hx_nxt; hy_r <= hy_nxt;
    wv_r <= wv_nxt;
    lh_r <= lh_nxt;
    ds_r <= ds_nxt; de_r <= de_nxt;
  end

  rcd_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rcd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_perp_dist   = perp_o_r;
  assign out_hit_side    = side_o_r;
  assign out_hit_x       = hx_r;
  assign out_hit_y       = hy_r;
  assign out_wall_value  = wv_r;
  assign out_slice_len   = lh_r;
  assign out_span_top    = ds_r;
  assign out_span_bot    = de_r;

endmodule

FILE: test/testbench.sv
// Testbench for grid_ray_caster_dda_top: map writes, ray casts and screen settings.
// Predicts each result word in place and checks it against the block's output.
// Depends on rcd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import rcd_pkg::*;

  typedef struct {
    logic        req_type;
    logic [4:0]  cell_x, cell_y;
    logic [3:0]  cell_value;
    logic [10:0] column;
    logic [14:0] pos_x, pos_y;
    logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  } request_t;

  typedef struct {
    status_t     status;
    logic [25:0] perp_dist;
    logic        hit_side;
    logic [4:0]  hit_x, hit_y;
    logic [3:0]  wall_value;
    logic [15:0] slice_len;
    logic [10:0] span_top, span_bot;
  } column_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  request_t rq = '{default: '0};
  logic out_valid;
  logic [1:0] out_status;
  logic [25:0] out_perp_dist;
  logic out_hit_side;
  logic [4:0] out_hit_x, out_hit_y;
  logic [3:0] out_wall_value;
  logic [15:0] out_slice_len;
  logic [10:0] out_span_top, out_span_bot;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [11:0] cfg_wdata = '0;

  logic [3:0] map_img [MAP_SIZE][MAP_SIZE];
  logic [11:0] scr_width, scr_height;
  column_t pending_cols[$];
  int mismatches = 0;
  int casts_seen = 0, walls_seen = 0, leaves_seen = 0, writes_seen = 0;

  always #5 clk = ~clk;

  grid_ray_caster_dda_top dut (
    .clk, .rst_n, .start, .busy,
    .in_req_type(rq.req_type), .in_cell_x(rq.cell_x), .in_cell_y(rq.cell_y),
    .in_cell_value(rq.cell_value), .in_column(rq.column),
    .in_pos_x(rq.pos_x), .in_pos_y(rq.pos_y), .in_dir_x(rq.dir_x), .in_dir_y(rq.dir_y),
    .in_plane_x(rq.plane_x), .in_plane_y(rq.plane_y),
    .out_valid, .out_status, .out_perp_dist, .out_hit_side, .out_hit_x, .out_hit_y,
    .out_wall_value, .out_slice_len, .out_span_top, .out_span_bot,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  function automatic longint step_dist(longint rd);
    longint a, q;
    a = rd < 0 ? -rd : rd;
    if (a == 0) return longint'(DIST_MAX);
    q = (longint'(1) << 30) / a;
    return q > longint'(DIST_MAX) ? longint'(DIST_MAX) : q;
  endfunction

  function automatic column_t cast_column(request_t r);
    column_t c;
    longint w, h, cam, rx, ry, ddx, ddy, mx, my, fx, fy, sdx, sdy, stx, sty;
    longint perp, lh, ds, de;
    int side, hit;
    logic [3:0] val;
    c = '{status: ST_LEFT, default: '0};
    w = scr_width == 0 ? 1 : scr_width;
    h = scr_height;
    cam = (longint'(r.column) * 2 * 16384) / w - 16384;
    rx = longint'(r.dir_x) + ((longint'(r.plane_x) * cam) >>> 14);
    ry = longint'(r.dir_y) + ((longint'(r.plane_y) * cam) >>> 14);
    ddx = step_dist(rx);
    ddy = step_dist(ry);
    mx = r.pos_x >> 10;
    my = r.pos_y >> 10;
    fx = r.pos_x & 1023;
    fy = r.pos_y & 1023;
    sdx = ((rx < 0 ? fx : 1024 - fx) * ddx) >> 10;
    sdy = ((ry < 0 ? fy : 1024 - fy) * ddy) >> 10;
    stx = rx < 0 ? -1 : 1;
    sty = ry < 0 ? -1 : 1;
    side = 0;
    hit = 0;
    val = '0;
    if (mx >= MAP_SIZE || my >= MAP_SIZE) return c;
    for (int n = 0; n < STEP_MAX; n++) begin
      if (sdx < sdy) begin
        sdx += ddx; mx += stx; side = 0;
      end else begin
        sdy += ddy; my += sty; side = 1;
      end
      if (mx < 0 || my < 0 || mx >= MAP_SIZE || my >= MAP_SIZE) break;
      val = map_img[my][mx];
      if (val != 0) begin
        hit = 1;
        break;
      end
    end
    if (hit == 0) return c;
    perp = side == 0 ? sdx - ddx : sdy - ddy;
    if (perp > longint'(DIST_MAX)) perp = DIST_MAX;
    if (perp == 0) lh = LH_MAX;
    else begin
      lh = (h << 16) / perp;
      if (lh > longint'(LH_MAX)) lh = LH_MAX;
    end
    ds = h / 2 - lh / 2;
    if (ds < 0) ds = 0;
    de = lh / 2 + h / 2;
    if (de >= h) de = h - 1;
    if (de < 0) de = 0;
    if (de > 2047) de = 2047;
    if (ds > 2047) ds = 2047;
    c.status = ST_HIT;
    c.perp_dist = perp[25:0];
    c.hit_side = side[0];
    c.hit_x = mx[4:0];
    c.hit_y = my[4:0];
    c.wall_value = val;
    c.slice_len = lh[15:0];
    c.span_top = ds[10:0];
    c.span_bot = de[10:0];
    return c;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_word(request_t r);
    int g;
    start <= 1'b1;
    rq <= r;
    do @(posedge clk); while (busy);
    if (r.req_type == 1'b0) begin
      map_img[r.cell_y][r.cell_x] = r.cell_value;
      pending_cols.push_back('{status: ST_WRITE, default: '0});
    end else begin
      pending_cols.push_back(cast_column(r));
    end
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_cols.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_screen(logic [11:0] w, logic [11:0] h);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= CFG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    scr_width = w;
    cfg_addr <= CFG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    scr_height = h;
    cfg_we <= 1'b0;
  endtask

  function automatic request_t map_write(int x, int y, int v);
    request_t r;
    r = '{default: '0};
    r.cell_x = 5'(x);
    r.cell_y = 5'(y);
    r.cell_value = 4'(v);
    return r;
  endfunction

  function automatic request_t ray(int col, int px, int py, int dx, int dy, int plx, int ply);
    request_t r;
    r = '{default: '0};
    r.req_type = 1'b1;
    r.column = 11'(col);
    r.pos_x = 15'(px);
    r.pos_y = 15'(py);
    r.dir_x = 16'(dx);
    r.dir_y = 16'(dy);
    r.plane_x = 16'(plx);
    r.plane_y = 16'(ply);
    return r;
  endfunction

  function automatic request_t random_ray();
    request_t r;
    r = ray($urandom_range(2047), $urandom_range(32767), $urandom_range(32767),
            $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(3) == 0) begin
      r.dir_x = $signed(16'($urandom_range(32767, 0))) - 16384;
      r.plane_x = $urandom_range(1) ? 16'sd0 : 16'sd10813;
    end
    return r;
  endfunction

  task automatic test_empty_map();
    send_word(ray(320, 16 * 1024 + 512, 16 * 1024 + 512, 16384, 0, 0, 10813));
    send_word(ray(0, 0, 0, -32768, -32768, 32767, 32767));
    send_word(ray(2047, 32767, 32767, 32767, 32767, -32768, -32768));
  endtask

  task automatic test_map_edges();
    send_word(map_write(0, 0, 15));
    send_word(map_write(31, 31, 1));
    send_word(map_write(31, 0, 8));
    send_word(map_write(0, 31, 7));
    send_word(map_write(0, 0, 0));
    for (int i = 0; i < 32; i += 4) send_word(map_write(i, 5, 4'(i + 1)));
    send_word(map_write(10, 20, 9));
  endtask

  task automatic test_cast_cases();
    // zero ray, flush against a wall, diagonal, straight walls
    send_word(ray(320, 10 * 1024, 20 * 1024, 0, 0, 0, 0));
    send_word(ray(320, 11 * 1024, 20 * 1024 + 512, -16384, 0, 0, 0));
    send_word(ray(320, 12 * 1024, 10 * 1024, 0, -16384, 10813, 0));
    send_word(ray(0, 2 * 1024 + 100, 2 * 1024 + 100, -16384, -16384, 0, 0));
    send_word(ray(639, 30 * 1024 + 1023, 30 * 1024 + 1023, 16384, 16384, -8000, 8000));
    send_word(ray(1000, 16 * 1024, 16 * 1024, 0, -32768, 32767, 0));
  endtask

  task automatic test_screen_extremes();
    request_t near_wall;
    near_wall = ray(5, 11 * 1024, 20 * 1024 + 7, -16384, 0, 0, 10813);
    set_screen(12'd0, 12'd0);
    send_word(near_wall);
    send_word(ray(2047, 12 * 1024 + 3, 10 * 1024 + 900, 0, -16384, 10813, 0));
    set_screen(12'd1, 12'd4095);
    send_word(near_wall);
    send_word(ray(2047, 12 * 1024 + 3, 7 * 1024 + 1, 0, -16384, 10813, 0));
    set_screen(12'd2048, 12'd2048);
    send_word(near_wall);
    send_word(ray(2047, 12 * 1024 + 3, 15 * 1024, 0, -16384, 10813, 0));
    set_screen(12'd640, 12'd480);
  endtask

  task automatic test_random_scenes(int n_items);
    request_t r;
    for (int i = 0; i < 32; i++) begin
      send_word(map_write(i, 0, $urandom_range(15, 1)));
      send_word(map_write(i, 31, $urandom_range(15, 1)));
      send_word(map_write(0, i, $urandom_range(15, 1)));
      send_word(map_write(31, i, $urandom_range(15, 1)));
    end
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 99)
        set_screen(12'($urandom_range(2048, 1)), 12'($urandom_range(2048, 1)));
      if ($urandom_range(99) < 22) begin
        r = map_write($urandom_range(31), $urandom_range(31), $urandom_range(15));
        if ($urandom_range(3) == 0) r.cell_value = 0;
        r.column = 11'($urandom);
        send_word(r);
      end else begin
        send_word(random_ray());
      end
    end
  endtask

  always @(posedge clk) begin
    column_t e;
    if (rst_n && out_valid) begin
      if (pending_cols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, status %0d", out_status);
      end else begin
        e = pending_cols.pop_front();
        case (e.status)
          ST_WRITE: writes_seen++;
          ST_HIT: walls_seen++;
          default: leaves_seen++;
        endcase
        if (e.status != ST_WRITE) casts_seen++;
        if (out_status !== e.status || out_perp_dist !== e.perp_dist ||
            out_hit_side !== e.hit_side || out_hit_x !== e.hit_x ||
            out_hit_y !== e.hit_y || out_wall_value !== e.wall_value ||
            out_slice_len !== e.slice_len || out_span_top !== e.span_top ||
            out_span_bot !== e.span_bot) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp st=%0d d=%0d s=%0d x=%0d y=%0d v=%0d lh=%0d %0d..%0d",
                     e.status, e.perp_dist, e.hit_side, e.hit_x, e.hit_y,
                     e.wall_value, e.slice_len, e.span_top, e.span_bot);
            $display("         got st=%0d d=%0d s=%0d x=%0d y=%0d v=%0d lh=%0d %0d..%0d",
                     out_status, out_perp_dist, out_hit_side, out_hit_x, out_hit_y,
                     out_wall_value, out_slice_len, out_span_top, out_span_bot);
          end
        end
      end
    end
  end

  initial begin
    for (int y = 0; y < MAP_SIZE; y++)
      for (int x = 0; x < MAP_SIZE; x++) map_img[y][x] = '0;
    scr_width = WIDTH_RST;
    scr_height = HEIGHT_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_map();
    test_map_edges();
    test_cast_cases();
    test_screen_extremes();
    test_random_scenes(393);
    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d map writes and %0d casts (%0d walls hit, %0d rays out of grid)",
             writes_seen, casts_seen, walls_seen, leaves_seen);
    $display("screen sizes swept from 0x0 through 2048x2048 and 1x4095");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout, %0d words outstanding", pending_cols.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/rcd_pkg.sv
src/rcd_ram.sv
src/rcd_div.sv
src/grid_ray_caster_dda_top.sv
test/testbench.sv
